// ----- sv/notch_filter_with_jitter_histogram_unit_defines.svh -----
// ----------------------------------------------------------------------------
// notch filter with jitter histogram: assertion macros
// Shared concurrent assertion forms, sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NOTCH_FILTER_WITH_JITTER_HISTOGRAM_UNIT_DEFINES_SVH
`define NOTCH_FILTER_WITH_JITTER_HISTOGRAM_UNIT_DEFINES_SVH

// same-cycle implication
`define NFJH_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NFJH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/nfjh_pkg.sv -----
// ----------------------------------------------------------------------------
// nfjh_pkg
// Widths, constants and shared types of the notch filter / jitter histogram.
// ----------------------------------------------------------------------------
package nfjh_pkg;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int STAMP_W  = 32;
  localparam int PCOUNT_W = 16;
  localparam int FILT_W   = 16;
  localparam int JIT_W    = 32;
  localparam int TPU_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // histogram
  localparam int BINS  = 64;
  localparam int BIN_W = $clog2(BINS);
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic signed [JIT_W-1:0] BIN_LO = -(BINS / 2);
  localparam logic signed [JIT_W-1:0] BIN_HI = BINS / 2;
  localparam logic signed [JIT_W-1:0] MIN_RESET = 10000000;

  // divider: restoring, DIV_STEPS quotient bits per pipeline stage
  localparam int DIV_W      = STAMP_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;

  // notch accumulator
  localparam int ACC_W  = 27;
  localparam int FRAC_W = 8;
  localparam logic signed [ACC_W-1:0] K_X0   = 256;
  localparam logic signed [ACC_W-1:0] K_X1   = 503;
  localparam logic signed [ACC_W-1:0] K_X2   = 256;
  localparam logic signed [ACC_W-1:0] K_Y1   = 498;
  localparam logic signed [ACC_W-1:0] K_Y2   = 251;
  localparam logic signed [ACC_W-1:0] K_RND  = 128;
  localparam logic signed [ACC_W-1:0] ONE_S  = 1;
  localparam logic signed [ACC_W-1:0] ZERO_S = 0;

  // configuration reset values
  localparam logic [STAMP_W-1:0]  PERIOD_RESET = 25000;
  localparam logic [TPU_W-1:0]    TPU_RESET    = 50;
  localparam logic [PCOUNT_W-1:0] RUN_RESET    = 10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_TPU    = 2'd1,
    CFG_RUN    = 2'd2
  } cfg_reg_e;

  // per-item tag running beside the divider
  typedef struct packed {
    logic                     valid;
    logic                     active;
    logic                     timed;
    logic signed [FILT_W-1:0] filtered;
  } tag_t;

  // item entering the histogram stage
  typedef struct packed {
    logic                     valid;
    logic                     active;
    logic                     timed;
    logic signed [FILT_W-1:0] filtered;
    logic signed [JIT_W-1:0]  jitter;
  } hist_in_t;

  // finished result
  typedef struct packed {
    logic                     valid;
    logic                     active;
    logic                     timed;
    logic signed [FILT_W-1:0] filtered;
    logic signed [JIT_W-1:0]  jitter;
    logic [BIN_W-1:0]         bin;
    logic [CNT_W-1:0]         count;
    logic signed [JIT_W-1:0]  max_jit;
    logic signed [JIT_W-1:0]  min_jit;
  } res_t;

endpackage

// ----- sv/nfjh_div.sv -----
// ----------------------------------------------------------------------------
// nfjh_div
// Pipelined restoring divider, narrow divisor, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module nfjh_div (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [nfjh_pkg::DIV_W-1:0]    dividend_i,
  input  logic [nfjh_pkg::TPU_W-1:0]    divisor_i,
  output logic [nfjh_pkg::DIV_W-1:0]    quotient_o
);
  import nfjh_pkg::*;

  typedef struct packed {
    logic [TPU_W-1:0] rem;
    logic [DIV_W-1:0] dq;
  } div_st_t;

  div_st_t st_q [DIV_STAGES];

  function automatic div_st_t div_steps(div_st_t s, logic [TPU_W-1:0] d);
    logic [TPU_W:0] t;
    div_st_t        r;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t    = {r.rem, r.dq[DIV_W-1]};
      r.dq = {r.dq[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem   = TPU_W'(t - {1'b0, d});
        r.dq[0] = 1'b1;
      end else begin
        r.rem = t[TPU_W-1:0];
      end
    end
    return r;
  endfunction

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_st_t st_in;
    if (k == 0) begin : g_first
      assign st_in = '{rem: '0, dq: dividend_i};
    end else begin : g_next
      assign st_in = st_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[k] <= div_steps(st_in, divisor_i);
      end
    end
  end

  // remainder of the last stage is dropped
  assign quotient_o = st_q[DIV_STAGES-1].dq;

endmodule

// ----- sv/nfjh_notch.sv -----
// ----------------------------------------------------------------------------
// nfjh_notch
// Second-order notch section; feed-forward terms are summed one sample ahead.
// ----------------------------------------------------------------------------
module nfjh_notch (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [nfjh_pkg::SAMPLE_W-1:0]       sample_i,
  output logic signed [nfjh_pkg::FILT_W-1:0]  filtered_o
);
  import nfjh_pkg::*;

  logic [SAMPLE_W-1:0]      x1_q;
  logic signed [FILT_W-1:0] y1_q;
  logic signed [ACC_W-1:0]  pre_q, pre_d;
  logic signed [ACC_W-1:0]  x0_e, x1_e, y1_e, num, quo;
  logic                     neg_frac;

  assign x0_e = {{(ACC_W-SAMPLE_W){1'b0}}, sample_i};
  assign x1_e = {{(ACC_W-SAMPLE_W){1'b0}}, x1_q};
  assign y1_e = {{(ACC_W-FILT_W){y1_q[FILT_W-1]}}, y1_q};

  // pre_q already holds 256*x2 - 503*x1 - 251*y2 + 128
  assign num = x0_e * K_X0 + y1_e * K_Y1 + pre_q;

  // divide by 256 toward zero
  assign neg_frac = num[ACC_W-1] && (num[FRAC_W-1:0] != '0);
  assign quo      = (num >>> FRAC_W) + (neg_frac ? ONE_S : ZERO_S);

  assign filtered_o = quo[FILT_W-1:0];

  // terms for the next sample: x2 <- x1, x1 <- x0, y2 <- y1
  assign pre_d = x1_e * K_X2 - x0_e * K_X1 - y1_e * K_Y2 + K_RND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q  <= '0;
      y1_q  <= '0;
      pre_q <= K_RND;
    end else if (load_i) begin
      x1_q  <= sample_i;
      y1_q  <= quo[FILT_W-1:0];
      pre_q <= pre_d;
    end
  end

endmodule

// ----- sv/nfjh_hist.sv -----
// ----------------------------------------------------------------------------
// nfjh_hist
// Histogram memory read-modify-write with forwarding, plus min/max tracking.
// ----------------------------------------------------------------------------
module nfjh_hist (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  nfjh_pkg::hist_in_t  in_i,
  output nfjh_pkg::res_t      res_o
);
  import nfjh_pkg::*;

  logic [CNT_W-1:0]        mem_q [BINS];
  logic [BINS-1:0]         vld_q;
  logic [CNT_W-1:0]        rd_q;
  logic                    rd_vld_q;
  logic                    fwd_q;
  logic [CNT_W-1:0]        fwd_cnt_q;
  hist_in_t                r_q;
  logic [BIN_W-1:0]        r_bin_q;
  logic signed [JIT_W-1:0] max_q, min_q;

  logic signed [JIT_W-1:0] jit_off;
  logic [BIN_W-1:0]        bin_sel;
  logic [CNT_W-1:0]        cnt_cur, cnt_new;
  logic                    wr_en;
  logic signed [JIT_W-1:0] max_new, min_new;

  // clamp jitter + BINS/2 into the bin range
  assign jit_off = in_i.jitter + BIN_HI;
  always_comb begin
    if (in_i.jitter < BIN_LO) begin
      bin_sel = '0;
    end else if (in_i.jitter >= BIN_HI) begin
      bin_sel = BIN_W'(BINS - 1);
    end else begin
      bin_sel = jit_off[BIN_W-1:0];
    end
  end

  // entry never written reads as zero
  always_comb begin
    if (fwd_q) begin
      cnt_cur = fwd_cnt_q;
    end else if (rd_vld_q) begin
      cnt_cur = rd_q;
    end else begin
      cnt_cur = '0;
    end
  end

  assign cnt_new = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign wr_en   = adv_i && r_q.valid && r_q.timed;

  assign max_new = (r_q.timed && (r_q.jitter > max_q)) ? r_q.jitter : max_q;
  assign min_new = (r_q.timed && (r_q.jitter < min_q)) ? r_q.jitter : min_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[r_bin_q] <= cnt_new;
    end
    if (adv_i) begin
      rd_q      <= mem_q[bin_sel];
      fwd_cnt_q <= cnt_new;
      r_bin_q   <= bin_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
      r_q      <= '0;
      max_q    <= '0;
      min_q    <= MIN_RESET;
    end else if (adv_i) begin
      if (wr_en) begin
        vld_q[r_bin_q] <= 1'b1;
        max_q          <= max_new;
        min_q          <= min_new;
      end
      rd_vld_q <= vld_q[bin_sel];
      // same bin as the item being written back: memory read is stale
      fwd_q    <= wr_en && (bin_sel == r_bin_q);
      r_q      <= in_i;
    end
  end

  always_comb begin
    res_o          = '0;
    res_o.valid    = r_q.valid;
    res_o.active   = r_q.active;
    res_o.timed    = r_q.timed;
    res_o.filtered = r_q.filtered;
    res_o.max_jit  = max_new;
    res_o.min_jit  = min_new;
    if (r_q.timed) begin
      res_o.jitter = r_q.jitter;
      res_o.bin    = r_bin_q;
      res_o.count  = cnt_new;
    end
  end

endmodule

// ----- sv/notch_filter_with_jitter_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// notch_filter_with_jitter_histogram_unit
// 60 Hz notch IIR on ADC samples with sample-timing jitter statistics.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid_i / in_stall_o) carries sample, timestamp and the
//   producer count; each accepted transaction yields exactly one result
//   transaction on the output channel (out_valid_o / out_stall_i)
// - config writes (cfg_valid_i / cfg_ready_o) go to period_ticks, ticks_per_us
//   and run_length by index; ready is always high, write only while idle
// - path: the 8-stage jitter divider plus a jitter register, the histogram
//   read stage and the output register lie between an input and its result
// - throughput: one transaction per cycle unless stalled; the histogram memory
//   does one read and one write per cycle, forwarding between neighbors on the same bin
// - when the receiver stalls a held result, the pipeline still moves while
//   its last stage is empty, then in_stall_o rises until the result is taken
// - reset sets the config registers to their defaults, clears the filter history
//   and histogram valid bits, zeroes max and presets min, at once; no clearing pass
// ----------------------------------------------------------------------------
`include "notch_filter_with_jitter_histogram_unit_defines.svh"

module notch_filter_with_jitter_histogram_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [nfjh_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [nfjh_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [nfjh_pkg::SAMPLE_W-1:0]          sample_i,
  input  logic [nfjh_pkg::STAMP_W-1:0]           timestamp_i,
  input  logic [nfjh_pkg::PCOUNT_W-1:0]          producer_count_i,
  // output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   active_o,
  output logic signed [nfjh_pkg::FILT_W-1:0]     filtered_o,
  output logic                                   timed_o,
  output logic signed [nfjh_pkg::JIT_W-1:0]      jitter_us_o,
  output logic [nfjh_pkg::BIN_W-1:0]             bin_index_o,
  output logic [nfjh_pkg::CNT_W-1:0]             bin_count_o,
  output logic signed [nfjh_pkg::JIT_W-1:0]      max_jitter_o,
  output logic signed [nfjh_pkg::JIT_W-1:0]      min_jitter_o
);
  import nfjh_pkg::*;

  logic [STAMP_W-1:0]       period_q;
  logic [TPU_W-1:0]         tpu_q;
  logic [PCOUNT_W-1:0]      run_q;
  logic [STAMP_W-1:0]       last_q;
  logic                     first_q;
  tag_t                     tag_q [DIV_STAGES];
  hist_in_t                 j_q;
  res_t                     out_q;

  logic                     adv;
  logic                     accept;
  logic                     act;
  logic [TPU_W-1:0]         div_sel;
  logic [STAMP_W-1:0]       diff;
  logic [DIV_W-1:0]         q_diff, q_per;
  logic signed [FILT_W-1:0] y0;
  res_t                     hist_res;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      tpu_q    <= TPU_RESET;
      run_q    <= RUN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PERIOD: period_q <= cfg_data_i[STAMP_W-1:0];
        CFG_TPU:    tpu_q    <= cfg_data_i[TPU_W-1:0];
        CFG_RUN:    run_q    <= cfg_data_i[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves unless a finished result waits behind a stalled output
  assign adv        = !(hist_res.valid && out_q.valid && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  assign act     = producer_count_i < run_q;
  assign div_sel = (tpu_q == '0) ? TPU_W'(1) : tpu_q;
  assign diff    = timestamp_i - last_q;

  nfjh_notch u_notch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && act),
    .sample_i   (sample_i),
    .filtered_o (y0)
  );

  nfjh_div u_div_diff (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .dividend_i (diff),
    .divisor_i  (div_sel),
    .quotient_o (q_diff)
  );

  nfjh_div u_div_period (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .dividend_i (period_q),
    .divisor_i  (div_sel),
    .quotient_o (q_per)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      first_q <= 1'b0;
    end else if (accept && act) begin
      last_q  <= timestamp_i;
      first_q <= 1'b1;
    end
  end

  // tags travel in step with the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        tag_q[k] <= '0;
      end
      j_q <= '0;
    end else if (adv) begin
      tag_q[0].valid    <= accept;
      tag_q[0].active   <= act;
      tag_q[0].timed    <= act && first_q;
      tag_q[0].filtered <= act ? y0 : '0;
      for (int k = 1; k < DIV_STAGES; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      j_q.valid    <= tag_q[DIV_STAGES-1].valid;
      j_q.active   <= tag_q[DIV_STAGES-1].active;
      j_q.timed    <= tag_q[DIV_STAGES-1].timed;
      j_q.filtered <= tag_q[DIV_STAGES-1].filtered;
      j_q.jitter   <= q_diff - q_per;
    end
  end

  nfjh_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .in_i   (j_q),
    .res_o  (hist_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (adv) begin
      if (hist_res.valid) begin
        out_q <= hist_res;
      end else if (!out_stall_i) begin
        out_q.valid <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_q.valid;
  assign active_o     = out_q.active;
  assign filtered_o   = out_q.filtered;
  assign timed_o      = out_q.timed;
  assign jitter_us_o  = out_q.jitter;
  assign bin_index_o  = out_q.bin;
  assign bin_count_o  = out_q.count;
  assign max_jitter_o = out_q.max_jit;
  assign min_jitter_o = out_q.min_jit;

  `NFJH_ASSERT_IMPLIES(a_timed_active, out_valid_o && timed_o, active_o, "timed result not active")
  `NFJH_ASSERT_IMPLIES(a_count_nonzero, out_valid_o && timed_o, bin_count_o != '0, "bin count zero")
  `NFJH_ASSERT_IMPLIES(a_min_le_max, out_valid_o && timed_o, min_jitter_o <= max_jitter_o, "min above max")
  `NFJH_ASSERT_IMPLIES(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "stall without held result")
  `NFJH_ASSERT_NEXT(a_result_moves, hist_res.valid && !in_stall_o, out_valid_o, "result lost at output")

endmodule
